// ===== hw/rtl/acked_log_stream_sender_top_defines.svh =====
// Assertion macros for the acked log stream sender.
// Used by the top level; clock and reset are taken from the including module.
`ifndef ACKED_LOG_STREAM_SENDER_TOP_DEFINES_SVH
`define ACKED_LOG_STREAM_SENDER_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_NEXT(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("assertion failed");
`define ASSERT_NOW(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("assertion failed");
`else
`define ASSERT_NEXT(name, pre, post)
`define ASSERT_NOW(name, pre, post)
`endif
`endif

// ===== hw/rtl/alss_pkg.sv =====
// Shared types, codes and helpers of the acked log stream sender.
// No dependencies.
package alss_pkg;

   localparam int SEQ_WIDTH  = 16;
   localparam int CNT_WIDTH  = 16;
   localparam int DIV_STEPS  = 16;
   localparam int STEP_WIDTH = $clog2(DIV_STEPS);

   localparam logic [15:0] MAX_MESSAGES_RST      = 16'd8;
   localparam logic [15:0] MAX_RATE_FACTOR_RST   = 16'd256;
   localparam logic [7:0]  TARGET_SYSTEM_RST     = 8'd1;
   localparam logic [7:0]  TARGET_COMPONENT_RST  = 8'd0;
   localparam logic [15:0] ACK_TIMEOUT_TICKS_RST = 16'd50;
   localparam logic [7:0]  ACK_MAX_TRIES_RST     = 8'd50;
   localparam logic [15:0] START_TIMEOUT_RST     = 16'd300;
   localparam logic [15:0] WINDOW_TICKS_RST      = 16'd1000;

   typedef enum logic [1:0] {
      FUNC_TICK      = 2'd0,
      FUNC_RECORD    = 2'd1,
      FUNC_LOG_ACK   = 2'd2,
      FUNC_START_ACK = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ACT_NONE       = 3'd0,
      ACT_SEND_PLAIN = 3'd1,
      ACT_SEND_ACKED = 3'd2,
      ACT_RESEND     = 3'd3,
      ACT_FORWARD    = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NO_START  = 2'd1,
      ST_RETRY_OUT = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      CSR_MAX_MESSAGES      = 4'd0,
      CSR_MAX_RATE_FACTOR   = 4'd1,
      CSR_TARGET_SYSTEM     = 4'd2,
      CSR_TARGET_COMPONENT  = 4'd3,
      CSR_ACK_TIMEOUT_TICKS = 4'd4,
      CSR_ACK_MAX_TRIES     = 4'd5,
      CSR_START_TIMEOUT     = 4'd6,
      CSR_WINDOW_TICKS      = 4'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      CTL_IDLE,
      CTL_MUL,
      CTL_DIV,
      CTL_EMIT
   } ctl_state_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [15:0] record_seq;
      logic        need_ack;
      logic        record_valid;
      logic [15:0] ack_seq;
   } req_data_type;

   typedef struct packed {
      logic [2:0]  action;
      logic        record_taken;
      logic [15:0] out_seq;
      logic [7:0]  out_system;
      logic [7:0]  out_component;
      logic [1:0]  status;
      logic [15:0] rate_factor;
   } rsp_data_type;

   typedef struct packed {
      logic step;
      logic load_direct;
      logic mul_start;
      logic div_step;
      logic load_held;
   } ctl_cmd_type;

   typedef struct packed {
      logic need_div;
      logic div_last;
   } dp_status_type;

   function automatic logic [CNT_WIDTH-1:0] sat_inc(input logic [CNT_WIDTH-1:0] v);
      return (v == {CNT_WIDTH{1'b1}}) ? v : v + {{(CNT_WIDTH-1){1'b0}}, 1'b1};
   endfunction

endpackage

// ===== hw/rtl/alss_dp.sv =====
// Datapath: CSRs, sender state, event step logic, rate divider, output register.
// Depends on alss_pkg; driven by alss_ctrl through command and status structs.
module alss_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  alss_pkg::req_data_type req_data,
   input  logic                   csr_write,
   input  logic [3:0]             csr_index,
   input  logic [15:0]            csr_data,
   input  alss_pkg::ctl_cmd_type  cmd,
   output alss_pkg::dp_status_type stat,
   output alss_pkg::rsp_data_type rsp_data
);

   logic [15:0] max_messages_ff, max_rate_factor_ff, ack_timeout_ff;
   logic [15:0] start_timeout_ff, window_ticks_ff;
   logic [7:0]  target_system_ff, target_component_ff, ack_max_tries_ff;

   logic        awaiting_ff, awaiting_in;
   logic        pending_ff, pending_in;
   logic        seen_ff, seen_in;
   logic [15:0] pseq_ff, pseq_in;
   logic [7:0]  try_ff, try_in;
   logic [15:0] elapsed_ff, elapsed_in;
   logic [15:0] wcount_ff, wcount_in;
   logic [15:0] sent_ff, sent_in;
   logic [15:0] rate_ff, rate_in;

   logic [15:0] div_a_ff;
   logic [15:0] rem_ff, rem_in;
   logic [15:0] quo_ff, quo_in;
   logic [alss_pkg::STEP_WIDTH-1:0] cnt_ff;
   logic [31:0] prod;
   logic [16:0] shifted, diff;

   alss_pkg::rsp_data_type res_ff, res_in, rsp_data_ff, rsp_data_in;
   logic need_div;

   // event step
   always_comb begin
      logic        go;
      logic [15:0] tmp;
      go          = 1'b0;
      tmp         = '0;
      awaiting_in = awaiting_ff;
      pending_in  = pending_ff;
      seen_in     = seen_ff;
      pseq_in     = pseq_ff;
      try_in      = try_ff;
      elapsed_in  = elapsed_ff;
      wcount_in   = wcount_ff;
      sent_in     = sent_ff;
      rate_in     = rate_ff;
      need_div    = 1'b0;
      res_in      = '0;
      unique case (alss_pkg::func_type'(req_data.func))
         alss_pkg::FUNC_TICK: begin
            if (awaiting_ff) begin
               elapsed_in = alss_pkg::sat_inc(elapsed_ff);
               if (elapsed_in >= start_timeout_ff) res_in.status = alss_pkg::ST_NO_START;
            end else begin
               go = 1'b1;
               if (pending_ff) begin
                  if (seen_ff) begin
                     pending_in = 1'b0;
                  end else begin
                     go         = 1'b0;
                     tmp        = alss_pkg::sat_inc(elapsed_ff);
                     elapsed_in = tmp;
                     if (tmp >= ack_timeout_ff) begin
                        if (try_ff >= ack_max_tries_ff) begin
                           res_in.status = alss_pkg::ST_RETRY_OUT;
                        end else begin
                           try_in               = try_ff + 8'd1;
                           elapsed_in           = '0;
                           res_in.action        = alss_pkg::ACT_RESEND;
                           res_in.out_seq       = pseq_ff;
                           res_in.out_system    = target_system_ff;
                           res_in.out_component = target_component_ff;
                        end
                     end
                  end
               end
               if (go) begin
                  tmp       = alss_pkg::sat_inc(wcount_ff);
                  wcount_in = tmp;
                  if (tmp >= window_ticks_ff) begin
                     wcount_in = '0;
                     sent_in   = '0;
                     if (sent_ff < max_messages_ff) need_div = 1'b1;
                     else rate_in = max_rate_factor_ff;
                  end
               end
            end
         end
         alss_pkg::FUNC_RECORD: begin
            go = 1'b1;
            if (awaiting_ff) begin
               go = 1'b0;
               if (elapsed_ff >= start_timeout_ff) res_in.status = alss_pkg::ST_NO_START;
            end else if (pending_ff) begin
               if (seen_ff) begin
                  pending_in = 1'b0;
               end else begin
                  go = 1'b0;
                  if (elapsed_ff >= ack_timeout_ff && try_ff >= ack_max_tries_ff)
                     res_in.status = alss_pkg::ST_RETRY_OUT;
               end
            end
            if (go && sent_ff < max_messages_ff) begin
               res_in.record_taken = 1'b1;
               sent_in             = alss_pkg::sat_inc(sent_ff);
               if (req_data.record_valid) begin
                  res_in.out_seq       = req_data.record_seq;
                  res_in.out_system    = target_system_ff;
                  res_in.out_component = target_component_ff;
                  if (req_data.need_ack) begin
                     res_in.action = alss_pkg::ACT_SEND_ACKED;
                     try_in        = 8'd1;
                     elapsed_in    = '0;
                     pseq_in       = req_data.record_seq;
                     pending_in    = 1'b1;
                     seen_in       = 1'b0;
                  end else begin
                     res_in.action = alss_pkg::ACT_SEND_PLAIN;
                  end
               end
            end
         end
         alss_pkg::FUNC_LOG_ACK: begin
            if (req_data.ack_seq[alss_pkg::SEQ_WIDTH-1:0] ==
                pseq_ff[alss_pkg::SEQ_WIDTH-1:0]) begin
               seen_in        = 1'b1;
               res_in.action  = alss_pkg::ACT_FORWARD;
               res_in.out_seq = req_data.ack_seq;
            end
         end
         alss_pkg::FUNC_START_ACK: begin
            if (awaiting_ff) begin
               awaiting_in = 1'b0;
               elapsed_in  = '0;
               pending_in  = 1'b0;
            end
         end
         default: ;
      endcase
   end

   // restoring divide, one quotient bit per cycle
   assign prod    = 32'(max_rate_factor_ff) * 32'(div_a_ff);
   assign shifted = {rem_ff, quo_ff[15]};
   assign diff    = shifted - {1'b0, max_messages_ff};

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (cmd.mul_start) begin
         rem_in = prod[31:16];
         quo_in = prod[15:0];
      end else if (cmd.div_step) begin
         if (!diff[16]) begin
            rem_in = diff[15:0];
            quo_in = {quo_ff[14:0], 1'b1};
         end else begin
            rem_in = shifted[15:0];
            quo_in = {quo_ff[14:0], 1'b0};
         end
      end
   end

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (cmd.load_direct) begin
         rsp_data_in             = res_in;
         rsp_data_in.rate_factor = rate_in;
      end else if (cmd.load_held) begin
         rsp_data_in             = res_ff;
         rsp_data_in.rate_factor = rate_ff;
      end
   end

   assign stat.need_div = need_div;
   assign stat.div_last = (cnt_ff == alss_pkg::STEP_WIDTH'(alss_pkg::DIV_STEPS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         max_messages_ff     <= alss_pkg::MAX_MESSAGES_RST;
         max_rate_factor_ff  <= alss_pkg::MAX_RATE_FACTOR_RST;
         target_system_ff    <= alss_pkg::TARGET_SYSTEM_RST;
         target_component_ff <= alss_pkg::TARGET_COMPONENT_RST;
         ack_timeout_ff      <= alss_pkg::ACK_TIMEOUT_TICKS_RST;
         ack_max_tries_ff    <= alss_pkg::ACK_MAX_TRIES_RST;
         start_timeout_ff    <= alss_pkg::START_TIMEOUT_RST;
         window_ticks_ff     <= alss_pkg::WINDOW_TICKS_RST;
      end else if (csr_write) begin
         unique case (alss_pkg::csr_index_type'(csr_index))
            alss_pkg::CSR_MAX_MESSAGES:      max_messages_ff     <= csr_data;
            alss_pkg::CSR_MAX_RATE_FACTOR:   max_rate_factor_ff  <= csr_data;
            alss_pkg::CSR_TARGET_SYSTEM:     target_system_ff    <= csr_data[7:0];
            alss_pkg::CSR_TARGET_COMPONENT:  target_component_ff <= csr_data[7:0];
            alss_pkg::CSR_ACK_TIMEOUT_TICKS: ack_timeout_ff      <= csr_data;
            alss_pkg::CSR_ACK_MAX_TRIES:     ack_max_tries_ff    <= csr_data[7:0];
            alss_pkg::CSR_START_TIMEOUT:     start_timeout_ff    <= csr_data;
            alss_pkg::CSR_WINDOW_TICKS:      window_ticks_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         awaiting_ff <= 1'b1;
         pending_ff  <= 1'b0;
         seen_ff     <= 1'b0;
         pseq_ff     <= '0;
         try_ff      <= '0;
         elapsed_ff  <= '0;
         wcount_ff   <= '0;
         sent_ff     <= '0;
         rate_ff     <= alss_pkg::MAX_RATE_FACTOR_RST;
         cnt_ff      <= '0;
      end else begin
         if (cmd.step) begin
            awaiting_ff <= awaiting_in;
            pending_ff  <= pending_in;
            seen_ff     <= seen_in;
            pseq_ff     <= pseq_in;
            try_ff      <= try_in;
            elapsed_ff  <= elapsed_in;
            wcount_ff   <= wcount_in;
            sent_ff     <= sent_in;
            rate_ff     <= rate_in;
         end else if (cmd.div_step && stat.div_last) begin
            rate_ff <= quo_in;
         end
         if (cmd.mul_start) cnt_ff <= '0;
         else if (cmd.div_step) cnt_ff <= cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      rsp_data_ff <= rsp_data_in;
      if (cmd.step) begin
         div_a_ff <= sent_ff;
         res_ff   <= res_in;
      end
   end

   assign rsp_data = rsp_data_ff;

endmodule

// ===== hw/rtl/alss_ctrl.sv =====
// Controller: request intake, multiply/divide sequencing and response valid.
// Depends on alss_pkg; commands alss_dp.
module alss_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  alss_pkg::dp_status_type stat,
   output alss_pkg::ctl_cmd_type   cmd
);

   alss_pkg::ctl_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free, accept;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign accept   = req_valid && (state_ff == alss_pkg::CTL_IDLE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         alss_pkg::CTL_IDLE: begin
            if (accept) begin
               if (stat.need_div) state_in = alss_pkg::CTL_MUL;
               else if (!out_free) state_in = alss_pkg::CTL_EMIT;
            end
         end
         alss_pkg::CTL_MUL: state_in = alss_pkg::CTL_DIV;
         alss_pkg::CTL_DIV: begin
            if (stat.div_last) state_in = alss_pkg::CTL_EMIT;
         end
         alss_pkg::CTL_EMIT: begin
            if (out_free) state_in = alss_pkg::CTL_IDLE;
         end
         default: state_in = alss_pkg::CTL_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         alss_pkg::CTL_IDLE: begin
            cmd.step        = accept;
            cmd.load_direct = accept && !stat.need_div && out_free;
         end
         alss_pkg::CTL_MUL:  cmd.mul_start = 1'b1;
         alss_pkg::CTL_DIV:  cmd.div_step  = 1'b1;
         alss_pkg::CTL_EMIT: cmd.load_held = out_free;
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_direct || cmd.load_held) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= alss_pkg::CTL_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != alss_pkg::CTL_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hw/rtl/acked_log_stream_sender_top.sv =====
// Acked log stream sender, top level: controller plus datapath.
// Depends on alss_pkg, alss_ctrl, alss_dp and the assertion macro header.
//
// One response per request. A request's response loads straight into the output
// register when that register is free; a tick that closes a rate window with
// budget left over goes through intake, one multiply, 16 steps of the bit-serial
// restoring divider and the response load, with further requests stalled. CSR
// writes are always accepted (csr_ready is tied high) and must only be issued
// while no request is in work.
`include "acked_log_stream_sender_top_defines.svh"
module acked_log_stream_sender_top (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  alss_pkg::req_data_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output alss_pkg::rsp_data_type rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [3:0]             csr_index,
   input  logic [15:0]            csr_data
);

   alss_pkg::ctl_cmd_type   cmd;
   alss_pkg::dp_status_type stat;

   assign csr_ready = 1'b1;

   alss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   alss_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_data  (rsp_data)
   );

   `ASSERT_NEXT(a_mul_then_div, cmd.mul_start, cmd.div_step && !cmd.mul_start)
   `ASSERT_NEXT(a_div_ends, cmd.div_step && stat.div_last, !cmd.div_step)
   `ASSERT_NOW(a_no_step_while_busy, cmd.mul_start || cmd.div_step, req_stall)
   `ASSERT_NOW(a_taken_kind, rsp_valid && rsp_data.record_taken, rsp_data.action != alss_pkg::ACT_RESEND && rsp_data.action != alss_pkg::ACT_FORWARD)

endmodule

// ===== bench/alss_rsp_checker.sv =====
// Response checker for the acked log stream sender: watches the request, response
// and CSR channels, predicts every response and compares it field by field.
// Depends on alss_pkg.
module alss_rsp_checker
   import alss_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_stall,
   input  req_data_type req_data,
   input  logic         rsp_valid,
   input  logic         rsp_stall,
   input  rsp_data_type rsp_data,
   input  logic         csr_valid,
   input  logic         csr_ready,
   input  logic [3:0]   csr_index,
   input  logic [15:0]  csr_data,
   output int           mismatches,
   output int           outstanding,
   output int           n_checked,
   output int           n_resend,
   output int           n_forward,
   output int           n_alarm
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [15:0] cfg_budget, cfg_rate_max, cfg_ack_to, cfg_start_to, cfg_window;
   logic [7:0]  cfg_sys, cfg_comp, cfg_tries;

   logic        waiting_start, ack_open, ack_heard;
   logic [15:0] held_seq, tick_cnt, win_ticks, win_sent, rate_now;
   logic [7:0]  tries_used;

   rsp_data_type due_rsp_q[$];

   function automatic logic [15:0] bump16(input logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   // One event in, one response out; updates the sender state.
   function automatic rsp_data_type step_sender(input req_data_type r);
      rsp_data_type o;
      logic         go;
      logic [31:0]  prod;
      o  = '0;
      go = 1'b1;
      case (func_type'(r.func))
         FUNC_TICK: begin
            if (waiting_start) begin
               tick_cnt = bump16(tick_cnt);
               if (tick_cnt >= cfg_start_to) o.status = ST_NO_START;
            end else begin
               if (ack_open) begin
                  if (ack_heard) begin
                     ack_open = 1'b0;
                  end else begin
                     go = 1'b0;
                     tick_cnt = bump16(tick_cnt);
                     if (tick_cnt >= cfg_ack_to) begin
                        if (tries_used >= cfg_tries) begin
                           o.status = ST_RETRY_OUT;
                        end else begin
                           tries_used      = tries_used + 8'd1;
                           tick_cnt        = '0;
                           o.action        = ACT_RESEND;
                           o.out_seq       = held_seq;
                           o.out_system    = cfg_sys;
                           o.out_component = cfg_comp;
                        end
                     end
                  end
               end
               if (go) begin
                  win_ticks = bump16(win_ticks);
                  if (win_ticks >= cfg_window) begin
                     if (win_sent < cfg_budget) begin
                        prod     = 32'(cfg_rate_max) * 32'(win_sent);
                        rate_now = 16'(prod / 32'(cfg_budget));
                     end else begin
                        rate_now = cfg_rate_max;
                     end
                     win_sent  = '0;
                     win_ticks = '0;
                  end
               end
            end
         end
         FUNC_RECORD: begin
            if (waiting_start) begin
               go = 1'b0;
               if (tick_cnt >= cfg_start_to) o.status = ST_NO_START;
            end else if (ack_open) begin
               if (ack_heard) begin
                  ack_open = 1'b0;
               end else begin
                  go = 1'b0;
                  if (tick_cnt >= cfg_ack_to && tries_used >= cfg_tries)
                     o.status = ST_RETRY_OUT;
               end
            end
            if (go && win_sent < cfg_budget) begin
               o.record_taken = 1'b1;
               win_sent = bump16(win_sent);
               if (r.record_valid) begin
                  o.out_seq       = r.record_seq;
                  o.out_system    = cfg_sys;
                  o.out_component = cfg_comp;
                  if (r.need_ack) begin
                     o.action   = ACT_SEND_ACKED;
                     tries_used = 8'd1;
                     tick_cnt   = '0;
                     held_seq   = r.record_seq;
                     ack_open   = 1'b1;
                     ack_heard  = 1'b0;
                  end else begin
                     o.action = ACT_SEND_PLAIN;
                  end
               end
            end
         end
         FUNC_LOG_ACK: begin
            if (r.ack_seq == held_seq) begin
               ack_heard = 1'b1;
               o.action  = ACT_FORWARD;
               o.out_seq = r.ack_seq;
            end
         end
         FUNC_START_ACK: begin
            if (waiting_start) begin
               waiting_start = 1'b0;
               tick_cnt      = '0;
               ack_open      = 1'b0;
            end
         end
         default: ;
      endcase
      o.rate_factor = rate_now;
      return o;
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= 100) $display("[%0t] mismatch: %s", $time, what);
   endtask

   task automatic cmp_field(input string name, input logic [15:0] got, want);
      if (got !== want)
         report_mismatch($sformatf("response %0d %s: got 0x%0h, expected 0x%0h",
                                   n_checked, name, got, want));
   endtask

   always @(posedge clock) begin
      rsp_data_type want;
      if (reset) begin
         cfg_budget    = MAX_MESSAGES_RST;
         cfg_rate_max  = MAX_RATE_FACTOR_RST;
         cfg_sys       = TARGET_SYSTEM_RST;
         cfg_comp      = TARGET_COMPONENT_RST;
         cfg_ack_to    = ACK_TIMEOUT_TICKS_RST;
         cfg_tries     = ACK_MAX_TRIES_RST;
         cfg_start_to  = START_TIMEOUT_RST;
         cfg_window    = WINDOW_TICKS_RST;
         waiting_start = 1'b1;
         ack_open      = 1'b0;
         ack_heard     = 1'b0;
         held_seq      = '0;
         tries_used    = '0;
         tick_cnt      = '0;
         win_ticks     = '0;
         win_sent      = '0;
         rate_now      = MAX_RATE_FACTOR_RST;
         due_rsp_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_MAX_MESSAGES:      cfg_budget   = csr_data;
               CSR_MAX_RATE_FACTOR:   cfg_rate_max = csr_data;
               CSR_TARGET_SYSTEM:     cfg_sys      = csr_data[7:0];
               CSR_TARGET_COMPONENT:  cfg_comp     = csr_data[7:0];
               CSR_ACK_TIMEOUT_TICKS: cfg_ack_to   = csr_data;
               CSR_ACK_MAX_TRIES:     cfg_tries    = csr_data[7:0];
               CSR_START_TIMEOUT:     cfg_start_to = csr_data;
               CSR_WINDOW_TICKS:      cfg_window   = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (due_rsp_q.size() == 0) begin
               report_mismatch($sformatf("response %0d arrived with nothing expected",
                                         n_checked));
            end else begin
               want = due_rsp_q.pop_front();
               cmp_field("action", 16'(rsp_data.action), 16'(want.action));
               cmp_field("record_taken", 16'(rsp_data.record_taken),
                         16'(want.record_taken));
               cmp_field("out_seq", rsp_data.out_seq, want.out_seq);
               cmp_field("out_system", 16'(rsp_data.out_system), 16'(want.out_system));
               cmp_field("out_component", 16'(rsp_data.out_component),
                         16'(want.out_component));
               cmp_field("status", 16'(rsp_data.status), 16'(want.status));
               cmp_field("rate_factor", rsp_data.rate_factor, want.rate_factor);
            end
            n_checked++;
         end
         if (req_valid && !req_stall) begin
            want = step_sender(req_data);
            if (want.action == ACT_RESEND) n_resend++;
            if (want.action == ACT_FORWARD) n_forward++;
            if (want.status != ST_OK) n_alarm++;
            due_rsp_q.push_back(want);
         end
      end
      outstanding = due_rsp_q.size();
   end

endmodule

// ===== bench/acked_log_stream_sender_top_tb.sv =====
// Testbench top for the acked log stream sender: clock, reset, request and CSR
// stimulus, response back-pressure and the final verdict.
// Depends on alss_pkg, acked_log_stream_sender_top and alss_rsp_checker.
module acked_log_stream_sender_top_tb
   import alss_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HOLD_CYCLES = 250;

   logic         clock;
   logic         reset      = 1'b1;
   logic         req_valid  = 1'b0;
   logic         req_stall;
   req_data_type req_data   = '0;
   logic         rsp_valid;
   logic         rsp_stall  = 1'b0;
   rsp_data_type rsp_data;
   logic         csr_valid  = 1'b0;
   logic         csr_ready;
   logic [3:0]   csr_index  = '0;
   logic [15:0]  csr_data   = '0;

   int mismatches, outstanding, n_checked, n_resend, n_forward, n_alarm;
   int requests, settings_used;
   int hold_asks;
   bit calm;
   logic [15:0] last_acked = '0;

   acked_log_stream_sender_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   alss_rsp_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .mismatches  (mismatches),
      .outstanding (outstanding),
      .n_checked   (n_checked),
      .n_resend    (n_resend),
      .n_forward   (n_forward),
      .n_alarm     (n_alarm)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic int pick_gap();
      int k;
      k = $urandom_range(0, 99);
      if (k < 55) return 0;
      if (k < 88) return $urandom_range(1, 3);
      if (k < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic req_data_type ev(input func_type f, input logic [15:0] rseq,
                                       input logic need, input logic ok,
                                       input logic [15:0] aseq);
      req_data_type d;
      d.func         = f;
      d.record_seq   = rseq;
      d.need_ack     = need;
      d.record_valid = ok;
      d.ack_seq      = aseq;
      return d;
   endfunction

   task automatic play(input req_data_type d, input int gap);
      req_data  <= d;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      requests++;
      if (d.func == FUNC_RECORD && d.need_ack) last_acked = d.record_seq;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop offering and wait for every response to drain
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (outstanding == 0);
      @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [15:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic configure(input logic [15:0] budget, rmax, input logic [7:0] sys, comp,
                            input logic [15:0] ack_to, input logic [7:0] tries,
                            input logic [15:0] start_to, win);
      settle();
      write_csr(CSR_MAX_MESSAGES, budget);
      write_csr(CSR_MAX_RATE_FACTOR, rmax);
      write_csr(CSR_TARGET_SYSTEM, {8'd0, sys});
      write_csr(CSR_TARGET_COMPONENT, {8'd0, comp});
      write_csr(CSR_ACK_TIMEOUT_TICKS, ack_to);
      write_csr(CSR_ACK_MAX_TRIES, {8'd0, tries});
      write_csr(CSR_START_TIMEOUT, start_to);
      write_csr(CSR_WINDOW_TICKS, win);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   task automatic run_phase(input int count, input bit squeeze);
      req_data_type d;
      int k, i, done, gap;
      bit useful;
      i    = 0;
      done = 0;
      calm = 1'b1;
      while (done < count) begin
         if (i == 30) calm = 1'b0;
         if (i == count / 2) settle();
         if (squeeze && i == 60) hold_asks++;
         k = $urandom_range(0, 99);
         d.record_seq   = 16'($urandom);
         d.ack_seq      = 16'($urandom);
         d.need_ack     = 1'($urandom);
         d.record_valid = ($urandom_range(0, 9) != 0);
         useful = 1'b1;
         if (k < 45) begin
            d.func = FUNC_TICK;
         end else if (k < 75) begin
            d.func     = FUNC_RECORD;
            d.need_ack = ($urandom_range(0, 9) < 4);
         end else if (k < 95) begin
            d.func = FUNC_LOG_ACK;
            if ($urandom_range(0, 3) != 0) d.ack_seq = last_acked;
            else useful = 1'b0;
         end else begin
            d.func = FUNC_START_ACK;
            useful = 1'b0;
         end
         gap = (calm || (squeeze && i >= 60 && i < 100)) ? 0 : pick_gap();
         play(d, gap);
         if (useful) done++;
         i++;
      end
   endtask

   // receiver back-pressure
   initial begin
      int  k, n, hold_done;
      bit  s;
      hold_done = 0;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (hold_asks != hold_done) begin
            s         = 1'b1;
            n         = HOLD_CYCLES;
            hold_done = hold_asks;
         end else if (calm) begin
            s = 1'b0;
            n = 1;
         end else begin
            k = $urandom_range(0, 99);
            if (k < 45) begin
               s = 1'b0;
               n = $urandom_range(1, 30);
            end else if (k < 90) begin
               s = 1'b1;
               n = $urandom_range(1, 3);
            end else if (k < 98) begin
               s = 1'b1;
               n = $urandom_range(4, 15);
            end else begin
               s = 1'b1;
               n = $urandom_range(30, 80);
            end
         end
         rsp_stall <= s;
         repeat (n) begin
            @(posedge clock);
            if (hold_asks != hold_done && !s) break;
         end
      end
   end

   initial begin
      #20_000_000;
      $display("Mismatches found");
      $finish;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // before the start ack, reset settings
      play(ev(FUNC_TICK, 16'h0000, 1'b0, 1'b1, 16'h0000), pick_gap());
      play(ev(FUNC_RECORD, 16'h8000, 1'b1, 1'b1, 16'h0000), pick_gap());

      // short start timeout, then start
      configure(16'd8, 16'd256, 8'd1, 8'd0, 16'd50, 8'd50, 16'd3, 16'd1000);
      play(ev(FUNC_TICK, 16'h0000, 1'b0, 1'b1, 16'h0000), pick_gap());
      play(ev(FUNC_RECORD, 16'h0001, 1'b0, 1'b1, 16'h0000), pick_gap());
      play(ev(FUNC_TICK, 16'h0000, 1'b0, 1'b1, 16'h0000), pick_gap());
      play(ev(FUNC_RECORD, 16'h0002, 1'b0, 1'b1, 16'h0000), pick_gap());
      play(ev(FUNC_LOG_ACK, 16'h0000, 1'b0, 1'b0, 16'h0000), pick_gap());
      play(ev(FUNC_START_ACK, 16'h0000, 1'b0, 1'b0, 16'h0000), pick_gap());
      play(ev(FUNC_START_ACK, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF), pick_gap());

      // sends, resends, retry exhaustion, budget and rate update
      configure(16'd3, 16'hFFFF, 8'hFF, 8'hAA, 16'd2, 8'd2, 16'd1, 16'd2);
      play(ev(FUNC_RECORD, 16'hFFFF, 1'b0, 1'b1, 16'h0000), pick_gap());
      play(ev(FUNC_RECORD, 16'h1111, 1'b1, 1'b0, 16'h0000), pick_gap());
      play(ev(FUNC_RECORD, 16'h0000, 1'b1, 1'b1, 16'h0000), pick_gap());
      play(ev(FUNC_RECORD, 16'h2222, 1'b0, 1'b1, 16'h0000), pick_gap());
      play(ev(FUNC_LOG_ACK, 16'h0000, 1'b0, 1'b0, 16'hFFFF), pick_gap());
      repeat (4) play(ev(FUNC_TICK, 16'h0000, 1'b0, 1'b0, 16'h0000), pick_gap());
      play(ev(FUNC_RECORD, 16'h3333, 1'b0, 1'b1, 16'h0000), pick_gap());
      play(ev(FUNC_LOG_ACK, 16'h0000, 1'b0, 1'b0, 16'h0000), pick_gap());
      play(ev(FUNC_TICK, 16'h0000, 1'b0, 1'b0, 16'h0000), pick_gap());
      play(ev(FUNC_RECORD, 16'h4444, 1'b0, 1'b1, 16'h0000), pick_gap());
      play(ev(FUNC_TICK, 16'h0000, 1'b0, 1'b0, 16'h0000), pick_gap());
      play(ev(FUNC_RECORD, 16'h0005, 1'b0, 1'b1, 16'h0000), pick_gap());
      repeat (2) play(ev(FUNC_TICK, 16'h0000, 1'b0, 1'b0, 16'h0000), pick_gap());

      for (int p = 0; p < 8; p++) begin
         case (p)
            0: configure(16'd4, 16'd256, 8'($urandom), 8'($urandom), 16'd3, 8'd3,
                         16'd300, 16'd10);
            1: configure(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF,
                         16'hFFFF, 16'hFFFF);
            2: configure(16'd1, 16'd0, 8'd0, 8'd0, 16'd1, 8'd1, 16'd1, 16'd1);
            3: configure(16'd0, 16'h8001, 8'h5A, 8'hA5, 16'd0, 8'd0, 16'd0, 16'd0);
            7: configure(16'($urandom_range(13, 3000)), 16'($urandom), 8'($urandom),
                         8'($urandom), 16'($urandom_range(1, 6)), 8'($urandom_range(1, 4)),
                         16'($urandom_range(1, 65535)), 16'($urandom_range(2, 40)));
            default: configure(16'($urandom_range(1, 12)), 16'($urandom), 8'($urandom),
                               8'($urandom), 16'($urandom_range(1, 6)),
                               8'($urandom_range(1, 4)), 16'($urandom_range(1, 65535)),
                               16'($urandom_range(2, 40)));
         endcase
         run_phase(200, p == 4);
      end

      settle();
      repeat (25) @(posedge clock);
      $display("Drove %0d requests under %0d register settings; checked %0d responses.",
               requests, settings_used, n_checked);
      $display("Seen: %0d resends, %0d forwarded acks, %0d error statuses.",
               n_resend, n_forward, n_alarm);
      if (mismatches == 0 && outstanding == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
